FILE: sv/sfpc_pkg.sv
// sfpc_pkg: shared types and constants for the sync-framed packet checker
// no dependencies; imported by sfpc_parser and sync_framed_packet_checker

package sfpc_pkg;

    localparam logic [7:0] SYNC_FIRST         = 8'h75;
    localparam logic [7:0] SYNC_SECOND        = 8'h65;
    localparam logic [7:0] WANTED_DESC_RST    = 8'h01;
    localparam logic [7:0] WANTED_FIELD_RST   = 8'hF1;

    localparam int         OUT_TDATA_W        = 64;
    localparam int         APB_ADDR_W         = 3;

    // register indexes, taken from paddr[2]
    localparam logic       REG_WANTED_DESC    = 1'b0;
    localparam logic       REG_WANTED_FIELD   = 1'b1;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_DESC    = 3'd2,
        PH_LEN     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CKHI    = 3'd5,
        PH_CKLO    = 3'd6
    } t_phase;

    typedef struct packed {
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
        logic        wanted;
        logic        checksum_ok;
        logic [7:0]  first_field;
        logic [7:0]  payload_length;
        logic [7:0]  descriptor;
    } t_result;

endpackage

FILE: sv/sync_framed_packet_checker.sv
// sync_framed_packet_checker: top level with stream ports, apb registers and result register
// depends on sfpc_pkg and sfpc_parser
//
// Usage: received bytes come in one per beat on the s_axis channel. The block hunts
// for the sync pair 0x75 0x65, then reads descriptor, length, payload and a
// big-endian two-byte checksum. After the low checksum byte one result beat goes
// out on m_axis carrying the frame header, the second payload byte, both checksums,
// a checksum match flag and a wanted flag against two apb registers (wanted
// descriptor at 0x0, wanted field descriptor at 0x4).
// Throughput: one byte per cycle while no result beat waiting on m_axis holds up s_axis.
// Path: the last checksum byte of a frame passes the input register, then the result
// register, before its result beat is valid on m_axis.
// Reset (synchronous, active low) puts the parser in sync hunt, clears the sums and
// loads the registers with 0x01 and 0xF1.
// Stall: while a result waits on m_axis bytes keep being taken; only a byte that would
// produce a second result before the first is taken holds up s_axis.

module sync_framed_packet_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [7:0] rx_byte
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] descriptor, [15:8] payload_length, [23:16] first_field,
    // [24] checksum_ok, [25] wanted, [41:26] computed_checksum,
    // [57:42] received_checksum, [63:58] zero
    output logic [sfpc_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import sfpc_pkg::*;

    logic [7:0]  r_wdesc;
    logic [7:0]  r_wfield;
    logic        w_cfg_wr;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_emit;
    t_result     w_result;
    logic        w_out_free;
    logic        w_advance;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wdesc  <= WANTED_DESC_RST;
            r_wfield <= WANTED_FIELD_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_WANTED_DESC:  r_wdesc  <= pwdata[7:0];
                REG_WANTED_FIELD: r_wfield <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WANTED_DESC:  prdata = {24'd0, r_wdesc};
            REG_WANTED_FIELD: prdata = {24'd0, r_wfield};
            default:          prdata = '0;
        endcase
    end

    // input register feeds the parser; it advances unless a result would overwrite one
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_advance       = r_in_valid && (!w_emit || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    sfpc_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_advance),
        .i_byte         (r_in_byte),
        .i_wanted_desc  (r_wdesc),
        .i_wanted_field (r_wfield),
        .o_emit         (w_emit),
        .o_result       (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_emit |-> !r_out_valid || i_m_axis_tready)
        else $error("result beat overwritten before it was taken");

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |-> w_emit && r_out_valid && !i_m_axis_tready)
        else $error("input stalled without a pending result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_emit |=> r_out_valid)
        else $error("emitted result not held in result register");

endmodule

FILE: sv/sfpc_parser.sv
// sfpc_parser: frame state machine, running fletcher-style sums modulo 256 and result forming
// depends on sfpc_pkg; one byte is consumed in each cycle that i_valid is high

module sfpc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_wanted_desc,
    input  logic [7:0]        i_wanted_field,
    output logic              o_emit,
    output sfpc_pkg::t_result o_result
);
    import sfpc_pkg::*;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_sum1,    n_sum1;
    logic [7:0]  r_sum2,    n_sum2;
    logic [7:0]  r_desc,    n_desc;
    logic [7:0]  r_len,     n_len;
    logic [7:0]  r_left,    n_left;
    logic [1:0]  r_pidx,    n_pidx;
    logic [7:0]  r_field,   n_field;
    logic [7:0]  r_ckhi,    n_ckhi;

    logic [7:0]  w_acc1;
    logic [7:0]  w_acc2;
    logic [7:0]  w_left_dec;
    logic [15:0] w_comp;
    logic [15:0] w_recv;

    assign w_acc1     = r_sum1 + i_byte;
    assign w_acc2     = r_sum2 + w_acc1;
    assign w_left_dec = r_left - 8'd1;
    assign w_comp     = {r_sum1, r_sum2};
    assign w_recv     = {r_ckhi, i_byte};

    always_comb begin
        n_phase = r_phase;
        n_sum1  = r_sum1;
        n_sum2  = r_sum2;
        n_desc  = r_desc;
        n_len   = r_len;
        n_left  = r_left;
        n_pidx  = r_pidx;
        n_field = r_field;
        n_ckhi  = r_ckhi;
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte == SYNC_SECOND) begin
                    n_sum1  = w_acc1;
                    n_sum2  = w_acc2;
                    n_phase = PH_DESC;
                end else if (i_byte == SYNC_FIRST) begin
                    // broken pair, restart the hunt from this byte
                    n_sum1  = SYNC_FIRST;
                    n_sum2  = SYNC_FIRST;
                    n_field = '0;
                    n_pidx  = '0;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_DESC: begin
                n_desc  = i_byte;
                n_sum1  = w_acc1;
                n_sum2  = w_acc2;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_left  = i_byte;
                n_pidx  = '0;
                n_sum1  = w_acc1;
                n_sum2  = w_acc2;
                n_phase = (i_byte == 8'd0) ? PH_CKHI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (r_pidx == 2'd1) begin
                    n_field = i_byte;
                end
                // index saturates, only positions 0 and 1 matter
                if (r_pidx != 2'd2) begin
                    n_pidx = r_pidx + 2'd1;
                end
                n_sum1 = w_acc1;
                n_sum2 = w_acc2;
                n_left = w_left_dec;
                if (w_left_dec == 8'd0) begin
                    n_phase = PH_CKHI;
                end
            end
            PH_CKHI: begin
                n_ckhi  = i_byte;
                n_phase = PH_CKLO;
            end
            PH_CKLO: begin
                n_phase = PH_SYNC1;
            end
            default: begin
                if (i_byte == SYNC_FIRST) begin
                    n_sum1  = SYNC_FIRST;
                    n_sum2  = SYNC_FIRST;
                    n_field = '0;
                    n_pidx  = '0;
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_sum1  <= '0;
            r_sum2  <= '0;
            r_desc  <= '0;
            r_len   <= '0;
            r_left  <= '0;
            r_pidx  <= '0;
            r_field <= '0;
            r_ckhi  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_sum1  <= n_sum1;
            r_sum2  <= n_sum2;
            r_desc  <= n_desc;
            r_len   <= n_len;
            r_left  <= n_left;
            r_pidx  <= n_pidx;
            r_field <= n_field;
            r_ckhi  <= n_ckhi;
        end
    end

    assign o_emit                     = (r_phase == PH_CKLO);
    assign o_result.descriptor        = r_desc;
    assign o_result.payload_length    = r_len;
    assign o_result.first_field       = r_field;
    assign o_result.checksum_ok       = (w_comp == w_recv);
    assign o_result.wanted            = (r_desc == i_wanted_desc) &&
                                        (r_field == i_wanted_field);
    assign o_result.computed_checksum = w_comp;
    assign o_result.received_checksum = w_recv;

    a_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_phase == PH_CKLO |=> r_phase == PH_SYNC1)
        else $error("phase did not return to hunt after checksum beat");

    a_sync_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SYNC2 |-> r_sum1 == SYNC_FIRST && r_sum2 == SYNC_FIRST)
        else $error("running sums not seeded by first sync byte");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != 8'd0)
        else $error("payload phase with no bytes left");

endmodule

FILE: sim/testbench.sv
// testbench for sync_framed_packet_checker: byte stream in, frame result beats out, apb registers
// depends on sfpc_pkg and the rtl under sv/; self-contained, no files or arguments

`timescale 1ns / 100ps

module testbench;
    import sfpc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // running model of the deframer: sums, frame header and the queue of frames still due
    class frame_scoreboard;
        logic [7:0] wanted_desc;
        logic [7:0] wanted_field;
        t_phase     state;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] desc_q;
        logic [7:0] len_q;
        logic [7:0] left_q;
        logic [7:0] index_q;
        logic [7:0] field_q;
        logic [7:0] ck_hi;
        t_result    frames_due[$];
        int         errors;

        function new();
            wanted_desc  = WANTED_DESC_RST;
            wanted_field = WANTED_FIELD_RST;
            state        = PH_SYNC1;
            sum_a        = '0;
            sum_b        = '0;
            desc_q       = '0;
            len_q        = '0;
            left_q       = '0;
            index_q      = '0;
            field_q      = '0;
            ck_hi        = '0;
            errors       = 0;
        endfunction

        function void set_reg(logic idx, logic [7:0] value);
            if (idx == REG_WANTED_DESC)
                wanted_desc = value;
            else
                wanted_field = value;
        endfunction

        function void add_sum(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void open_frame();
            sum_a   = '0;
            sum_b   = '0;
            field_q = '0;
            index_q = '0;
            add_sum(SYNC_FIRST);
            state   = PH_SYNC2;
        endfunction

        function void note_byte(logic [7:0] b);
            t_result r;
            case (state)
                PH_SYNC2: begin
                    if (b == SYNC_SECOND) begin
                        add_sum(b);
                        state = PH_DESC;
                    end else if (b == SYNC_FIRST) begin
                        open_frame();
                    end else begin
                        state = PH_SYNC1;
                    end
                end
                PH_DESC: begin
                    desc_q = b;
                    add_sum(b);
                    state = PH_LEN;
                end
                PH_LEN: begin
                    len_q   = b;
                    left_q  = b;
                    index_q = '0;
                    add_sum(b);
                    state = (b == 8'd0) ? PH_CKHI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (index_q == 8'd1)
                        field_q = b;
                    index_q = index_q + 8'd1;
                    add_sum(b);
                    left_q = left_q - 8'd1;
                    if (left_q == 8'd0)
                        state = PH_CKHI;
                end
                PH_CKHI: begin
                    ck_hi = b;
                    state = PH_CKLO;
                end
                PH_CKLO: begin
                    r.descriptor        = desc_q;
                    r.payload_length    = len_q;
                    r.first_field       = field_q;
                    r.computed_checksum = {sum_a, sum_b};
                    r.received_checksum = {ck_hi, b};
                    r.checksum_ok       = (r.computed_checksum == r.received_checksum);
                    r.wanted            = (desc_q == wanted_desc) && (field_q == wanted_field);
                    frames_due.push_back(r);
                    state = PH_SYNC1;
                end
                default: begin
                    if (b == SYNC_FIRST)
                        open_frame();
                    else
                        state = PH_SYNC1;
                end
            endcase
        endfunction

        function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] beat);
            t_result got;
            t_result exp_r;
            got = beat[$bits(t_result)-1:0];
            if (frames_due.size() == 0) begin
                $error("result beat 0x%0h with no frame pending", beat);
                errors++;
                return;
            end
            exp_r = frames_due.pop_front();
            compare_field("descriptor", exp_r.descriptor, got.descriptor);
            compare_field("payload_length", exp_r.payload_length, got.payload_length);
            compare_field("first_field", exp_r.first_field, got.first_field);
            compare_field("checksum_ok", exp_r.checksum_ok, got.checksum_ok);
            compare_field("wanted", exp_r.wanted, got.wanted);
            compare_field("computed_checksum", exp_r.computed_checksum, got.computed_checksum);
            compare_field("received_checksum", exp_r.received_checksum, got.received_checksum);
            compare_field("padding", '0, beat[OUT_TDATA_W-1:$bits(t_result)]);
        endfunction
    endclass

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_valid  = 1'b0;
    logic [7:0]                s_data   = '0;
    logic                      m_ready  = 1'b0;
    logic                      apb_sel  = 1'b0;
    logic                      apb_en   = 1'b0;
    logic                      apb_wr   = 1'b0;
    logic [APB_ADDR_W-1:0]     apb_addr = '0;
    logic [31:0]               apb_wdata = '0;
    wire                       s_ready;
    wire                       m_valid;
    wire  [OUT_TDATA_W-1:0]    m_data;
    wire  [31:0]               apb_rdata;
    wire                       apb_ready;

    frame_scoreboard sb = new();
    int src_idle   = 0;
    int sink_stall = 0;
    int bytes_sent = 0;
    int cycles     = 0;

    sync_framed_packet_checker u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (apb_sel),
        .penable         (apb_en),
        .pwrite          (apb_wr),
        .paddr           (apb_addr),
        .pwdata          (apb_wdata),
        .prdata          (apb_rdata),
        .pready          (apb_ready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall);
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // well-formed frame with random payload, second byte field_byte if use_field; corrupt flips checksum bits
    task automatic send_frame(input logic [7:0] desc, input logic [7:0] len,
                              input logic [7:0] field_byte, input bit use_field,
                              input bit corrupt);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  pb;
        logic [15:0] ck;
        a = SYNC_FIRST;
        b = a;
        a = a + SYNC_SECOND;
        b = b + a;
        a = a + desc;
        b = b + a;
        a = a + len;
        b = b + a;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(desc);
        send_byte(len);
        for (int i = 0; i < len; i++) begin
            pb = (i == 1 && use_field) ? field_byte : 8'($urandom_range(0, 255));
            a = a + pb;
            b = b + a;
            send_byte(pb);
        end
        ck = {a, b};
        if (corrupt)
            ck = ck ^ 16'($urandom_range(1, 65535));
        send_byte(ck[15:8]);
        send_byte(ck[7:0]);
    endtask

    task automatic apb_write(input logic idx, input logic [7:0] value);
        @(negedge clk);
        apb_sel   <= 1'b1;
        apb_en    <= 1'b0;
        apb_wr    <= 1'b1;
        apb_addr  <= {idx, 2'b00};
        apb_wdata <= {24'd0, value};
        @(negedge clk);
        apb_en <= 1'b1;
        @(posedge clk);
        while (!apb_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        @(negedge clk);
        apb_sel <= 1'b0;
        apb_en  <= 1'b0;
        apb_wr  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic idx, input logic [7:0] exp_val);
        @(negedge clk);
        apb_sel  <= 1'b1;
        apb_en   <= 1'b0;
        apb_wr   <= 1'b0;
        apb_addr <= {idx, 2'b00};
        @(negedge clk);
        apb_en <= 1'b1;
        @(posedge clk);
        while (!apb_ready)
            @(posedge clk);
        sb.compare_field("prdata", {24'd0, exp_val}, apb_rdata);
        @(negedge clk);
        apb_sel <= 1'b0;
        apb_en  <= 1'b0;
    endtask

    // finish any frame in flight so that a register change never splits one
    task automatic close_and_drain();
        while (sb.state != PH_SYNC1)
            send_byte(8'h00);
        @(negedge clk);
        s_valid <= 1'b0;
        while (sb.frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_traffic(input int target);
        int          r;
        logic [7:0]  len;
        logic [7:0]  desc;
        logic [7:0]  fld;
        target = bytes_sent + target;
        while (bytes_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                case ($urandom_range(0, 19))
                    0:       len = 8'($urandom_range(17, 40));
                    1, 2, 3,
                    4, 5, 6,
                    7:       len = 8'($urandom_range(4, 16));
                    default: len = 8'($urandom_range(0, 3));
                endcase
                desc = ($urandom_range(0, 99) < 35) ? sb.wanted_desc
                                                     : 8'($urandom_range(0, 255));
                fld  = ($urandom_range(0, 99) < 35) ? sb.wanted_field
                                                     : 8'($urandom_range(0, 255));
                send_frame(desc, len, fld, 1'b1, $urandom_range(0, 99) < 15);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST
                                                          : 8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                // sync first byte then a random byte, which usually breaks the pair
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                // header only, the next frame's bytes are swallowed as its body
                send_byte(SYNC_FIRST);
                send_byte(SYNC_SECOND);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 4)));
            end
        end
        close_and_drain();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_read_check(REG_WANTED_DESC, WANTED_DESC_RST);
        apb_read_check(REG_WANTED_FIELD, WANTED_FIELD_RST);

        // directed: restart on a second first-sync byte, wanted frame
        send_byte(SYNC_FIRST);
        send_frame(8'h01, 8'd2, 8'hF1, 1'b1, 1'b0);
        // sync pair broken by another byte
        send_byte(8'h00);
        send_byte(SYNC_FIRST);
        send_byte(8'h12);
        // zero length with a bad checksum
        send_frame(8'hFF, 8'd0, 8'h00, 1'b0, 1'b1);
        // single payload byte, field descriptor stays zero
        send_frame(8'h00, 8'd1, 8'hFF, 1'b0, 1'b0);
        close_and_drain();

        // defaults, no idling; one longest frame
        send_frame(8'h01, 8'd255, 8'hF1, 1'b1, 1'b0);
        random_traffic(140);

        apb_write(REG_WANTED_DESC, 8'h00);
        apb_write(REG_WANTED_FIELD, 8'hFF);
        apb_read_check(REG_WANTED_FIELD, 8'hFF);
        src_idle = 80;
        random_traffic(140);

        apb_write(REG_WANTED_DESC, 8'hFF);
        apb_write(REG_WANTED_FIELD, 8'h00);
        apb_read_check(REG_WANTED_DESC, 8'hFF);
        src_idle   = 0;
        sink_stall = 80;
        send_frame(8'hFF, 8'd1, 8'h00, 1'b0, 1'b0);
        random_traffic(140);

        apb_write(REG_WANTED_DESC, 8'($urandom_range(0, 255)));
        apb_write(REG_WANTED_FIELD, 8'($urandom_range(0, 255)));
        src_idle   = 25;
        sink_stall = 25;
        random_traffic(140);

        repeat (10) @(posedge clk);
        if (sb.frames_due.size() == 0 && sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sync_framed_packet_checker.f
sv/sfpc_pkg.sv
sv/sfpc_parser.sv
sv/sync_framed_packet_checker.sv
sim/testbench.sv
